// ----- sv/mpd_pkg.sv -----
// Shared types and constants for the mouse packet decoder.
package mpd_pkg;

   localparam int MPD_QUEUE_DEPTH = 2;
   localparam int MPD_BUTTONS     = 3;

   localparam logic [1:0] KIND_MOVE = 2'd0;
   localparam logic [1:0] KIND_DOWN = 2'd1;
   localparam logic [1:0] KIND_UP   = 2'd2;

   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD  = 2'd2;

   typedef struct packed {
      logic [7:0]             move_x;
      logic [7:0]             move_y;
      logic [MPD_BUTTONS-1:0] buttons;
      logic [MPD_BUTTONS-1:0] changed;
   } job_type;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [7:0] move_x;
      logic [7:0] move_y;
      logic [1:0] button_number;
      logic       last;
   } event_type;

endpackage

// ----- sv/mpd_front.sv -----
// Front end: filters bytes, assembles packets and queues one job per packet.
module mpd_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_valid,
   input  logic            csr_data,
   input  logic            req_fire,
   input  logic            req_aux,
   input  logic [7:0]      req_byte,
   output logic            push,
   output mpd_pkg::job_type push_job
);
   import mpd_pkg::*;

   logic                   enabled_ff, enabled_in;
   logic [1:0]             pos_ff, pos_in;
   logic [7:0]             byte0_ff, byte0_in;
   logic [7:0]             byte1_ff, byte1_in;
   logic [MPD_BUTTONS-1:0] prev_ff, prev_in;
   logic                   take;

   assign take = req_fire && req_aux && enabled_ff;

   always_comb begin
      enabled_in = csr_valid ? csr_data : enabled_ff;
      pos_in     = pos_ff;
      byte0_in   = byte0_ff;
      byte1_in   = byte1_ff;
      prev_in    = prev_ff;
      push       = 1'b0;
      push_job.move_x  = byte1_ff;
      push_job.move_y  = 8'(8'd0 - req_byte);
      push_job.buttons = byte0_ff[MPD_BUTTONS-1:0];
      push_job.changed = byte0_ff[MPD_BUTTONS-1:0] ^ prev_ff;
      if (take) begin
         case (pos_ff)
            POS_SECOND: begin
               byte1_in = req_byte;
               pos_in   = POS_THIRD;
            end
            POS_THIRD: begin
               push    = 1'b1;
               prev_in = byte0_ff[MPD_BUTTONS-1:0];
               pos_in  = POS_FIRST;
            end
            default: begin
               byte0_in = req_byte;
               pos_in   = POS_SECOND;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b1;
         pos_ff     <= POS_FIRST;
         prev_ff    <= '0;
      end else begin
         enabled_ff <= enabled_in;
         pos_ff     <= pos_in;
         prev_ff    <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      byte0_ff <= byte0_in;
      byte1_ff <= byte1_in;
   end

endmodule

// ----- sv/mpd_queue.sv -----
// Small job queue between the packet front end and the event back end.
module mpd_queue #(
   parameter int QUEUE_DEPTH = mpd_pkg::MPD_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mpd_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output mpd_pkg::job_type head_job
);
   import mpd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type             mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- sv/mpd_back.sv -----
// Back end: expands one packet job into a move event and button events.
module mpd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  mpd_pkg::job_type   head_job,
   output logic               pop,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output mpd_pkg::event_type rsp_event
);
   import mpd_pkg::*;

   logic                   cur_valid_ff, cur_valid_in;
   job_type                cur_job_ff, cur_job_in;
   logic                   move_done_ff, move_done_in;
   logic [MPD_BUTTONS-1:0] mask_ff, mask_in;
   logic                   out_valid_ff, out_valid_in;
   event_type              out_event_ff, out_event_in;

   logic                   load;
   logic                   emit;
   logic [1:0]             sel;
   logic [MPD_BUTTONS-1:0] sel_bit;
   event_type              ev;

   always_comb begin
      sel = 2'd0;
      for (int i = MPD_BUTTONS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = 2'(i);
         end
      end
      sel_bit = MPD_BUTTONS'(1) << sel;
   end

   always_comb begin
      if (!move_done_ff) begin
         ev.event_kind    = KIND_MOVE;
         ev.move_x        = cur_job_ff.move_x;
         ev.move_y        = cur_job_ff.move_y;
         ev.button_number = 2'd0;
         ev.last          = (mask_ff == '0);
      end else begin
         ev.event_kind    = cur_job_ff.buttons[sel] ? KIND_DOWN : KIND_UP;
         ev.move_x        = 8'd0;
         ev.move_y        = 8'd0;
         ev.button_number = sel + 2'd1;
         ev.last          = ((mask_ff & ~sel_bit) == '0);
      end
   end

   assign load = !out_valid_ff || rsp_ready;
   assign emit = cur_valid_ff && load;
   assign pop  = head_valid && (!cur_valid_ff || (emit && ev.last));

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_job_in   = cur_job_ff;
      move_done_in = move_done_ff;
      mask_in      = mask_ff;
      out_valid_in = load ? emit : out_valid_ff;
      out_event_in = emit ? ev : out_event_ff;
      if (emit) begin
         if (ev.last) begin
            cur_valid_in = 1'b0;
         end else if (!move_done_ff) begin
            move_done_in = 1'b1;
         end else begin
            mask_in = mask_ff & ~sel_bit;
         end
      end
      if (pop) begin
         cur_valid_in = 1'b1;
         cur_job_in   = head_job;
         move_done_in = 1'b0;
         mask_in      = head_job.changed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_job_ff   <= cur_job_in;
      move_done_ff <= move_done_in;
      mask_ff      <= mask_in;
      out_event_ff <= out_event_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_event = out_event_ff;

endmodule

// ----- sv/mouse_packet_decoder.sv -----
// Mouse packet decoder top level: three-byte packets in, move/button events out.
// The move event of a packet passes through the queue, the current-job register and the output
// register after its third byte is taken. Throughput: one byte per cycle in while the queue is not full,
// one event per cycle out while rsp_tready is high; a packet gives 1 to 4 events, one per cycle.
// Reset (synchronous): position and button history cleared, events enabled, queue empty.
module mouse_packet_decoder #(
   parameter int QUEUE_DEPTH = mpd_pkg::MPD_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data,    // [0] events_enabled
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] aux_flag
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] move_x, [15:8] move_y, [17:16] button_number
   output logic [1:0]  rsp_tuser,   // [1:0] event_kind
   output logic        rsp_tlast
);
   import mpd_pkg::*;

   logic      req_fire;
   logic      push;
   job_type   push_job;
   logic      pop;
   logic      full;
   logic      head_valid;
   job_type   head_job;
   event_type rsp_event;

   assign csr_ready  = 1'b1;
   assign req_tready = !full;
   assign req_fire   = req_tvalid && req_tready;

   mpd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_data (csr_data),
      .req_fire (req_fire),
      .req_aux  (req_tuser),
      .req_byte (req_tdata),
      .push     (push),
      .push_job (push_job)
   );

   mpd_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (full),
      .head_valid(head_valid),
      .head_job  (head_job)
   );

   mpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_event (rsp_event)
   );

   assign rsp_tdata = {6'd0, rsp_event.button_number, rsp_event.move_y, rsp_event.move_x};
   assign rsp_tuser = rsp_event.event_kind;
   assign rsp_tlast = rsp_event.last;

`ifndef SYNTHESIS
   a_move_no_button: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_MOVE |-> rsp_tdata[17:16] == 2'd0)
      else $error("move event carries a button number");

   a_button_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_MOVE |-> rsp_tdata[17:16] != 2'd0
         && rsp_tdata[15:0] == 16'd0)
      else $error("button event has bad fields");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("job queued while queue full");

   a_pop_has_job: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("job taken from empty queue");
`endif

endmodule
